@@ rtl/core/dstdr_pkg.sv @@
// Shared types and constants for the dense slot table with dirty-run scanning.
// Used by every module under rtl/core except dstdr_slot_ram; depends on nothing.
package dstdr_pkg;

    localparam int SLOT_BITS     = 10;
    localparam int COUNT_BITS    = SLOT_BITS + 1;
    localparam int CAPACITY      = 1 << SLOT_BITS;
    localparam int OWNER_BITS    = 16;
    localparam int WLOG_BITS     = 3;
    localparam int TEXEL_SHIFT   = 2;
    localparam int X_BITS        = 6;
    localparam int Y_BITS        = 6;
    localparam int LEN_BITS      = 7;
    localparam int ROWSLOT_BITS  = 4;

    localparam logic [WLOG_BITS-1:0] WLOG_MIN   = 3'd2;
    localparam logic [WLOG_BITS-1:0] WLOG_MAX   = 3'd6;
    localparam logic [WLOG_BITS-1:0] WLOG_RESET = 3'd6;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_NEXT_RUN = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_NO_RUN   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RM_MOVE,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic                  dirty;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        entry_t               wr_data;
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_BITS-1:0]  slot_out;
        logic                  moved;
        logic [OWNER_BITS-1:0] moved_owner;
        logic [SLOT_BITS-1:0]  copy_from;
        logic [X_BITS-1:0]     run_x;
        logic [Y_BITS-1:0]     run_y;
        logic [LEN_BITS-1:0]   run_len;
        logic [SLOT_BITS-1:0]  run_first_slot;
        logic [COUNT_BITS-1:0] used_count;
    } rsp_t;

endpackage

@@ rtl/core/dense_slot_table_dirty_runs_core.sv @@
// Top level of the dense slot table with dirty-run scanning.
// Depends on dstdr_pkg, dstdr_slot_ram, dstdr_seq and dstdr_rsp_buf.
//
//   channel  handshake                 payload
//   req      req_valid / req_stall     opcode, slot_in, owner_in
//   rsp      rsp_valid / rsp_stall     status .. used_count
//   cfg      cfg_valid / cfg_ready     cfg_data (width_log2)
//
// Add, no-op, full add and bad remove pass through decode to the result; a remove that
// moves the last entry also passes through S_RM_MOVE, for the registered read of the slot RAM.
// A run request reads each slot from the cursor to the end of the run (one more read
// when the run ends on a clean slot): one RAM read a cycle.
// Reset needs no sweep: RAM entries are read only below the used count, and all
// of those have been written since reset.
// A stalled result sits in the output register while the next transaction runs.
module dense_slot_table_dirty_runs_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       opcode,
    input  logic [dstdr_pkg::SLOT_BITS-1:0]  slot_in,
    input  logic [dstdr_pkg::OWNER_BITS-1:0] owner_in,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic [dstdr_pkg::SLOT_BITS-1:0]  slot_out,
    output logic                             moved,
    output logic [dstdr_pkg::OWNER_BITS-1:0] moved_owner,
    output logic [dstdr_pkg::SLOT_BITS-1:0]  copy_from,
    output logic [dstdr_pkg::X_BITS-1:0]     run_x,
    output logic [dstdr_pkg::Y_BITS-1:0]     run_y,
    output logic [dstdr_pkg::LEN_BITS-1:0]   run_len,
    output logic [dstdr_pkg::SLOT_BITS-1:0]  run_first_slot,
    output logic [dstdr_pkg::COUNT_BITS-1:0] used_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dstdr_pkg::WLOG_BITS-1:0]  cfg_data
);

    dstdr_pkg::ram_req_t ram_req;
    dstdr_pkg::entry_t   ram_rd;
    dstdr_pkg::rsp_t     res;
    dstdr_pkg::rsp_t     rsp;
    logic                res_valid;
    logic                res_ready;

    dstdr_slot_ram #(
        .ADDR_BITS (dstdr_pkg::SLOT_BITS),
        .DATA_BITS ($bits(dstdr_pkg::entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd)
    );

    dstdr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .slot_in   (slot_in),
        .owner_in  (owner_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    dstdr_rsp_buf u_rsp_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign status         = rsp.status;
    assign slot_out       = rsp.slot_out;
    assign moved          = rsp.moved;
    assign moved_owner    = rsp.moved_owner;
    assign copy_from      = rsp.copy_from;
    assign run_x          = rsp.run_x;
    assign run_y          = rsp.run_y;
    assign run_len        = rsp.run_len;
    assign run_first_slot = rsp.run_first_slot;
    assign used_count     = rsp.used_count;

endmodule

@@ rtl/core/dstdr_slot_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the slot entries; no package dependency.
module dstdr_slot_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 17
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/dstdr_seq.sv @@
// Sequencer: decodes each transaction, runs read-modify-write on the slot RAM,
// walks dirty marks for run requests. Depends on dstdr_pkg.
module dstdr_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     opcode,
    input  logic [dstdr_pkg::SLOT_BITS-1:0]  slot_in,
    input  logic [dstdr_pkg::OWNER_BITS-1:0] owner_in,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dstdr_pkg::WLOG_BITS-1:0]  cfg_data,
    output dstdr_pkg::ram_req_t            ram_req,
    input  dstdr_pkg::entry_t              ram_rd,
    output logic                           res_valid,
    input  logic                           res_ready,
    output dstdr_pkg::rsp_t                res
);

    localparam int SB = dstdr_pkg::SLOT_BITS;
    localparam int CB = dstdr_pkg::COUNT_BITS;
    localparam int WB = dstdr_pkg::WLOG_BITS;
    localparam int RB = dstdr_pkg::ROWSLOT_BITS;
    localparam int XB = dstdr_pkg::X_BITS;
    localparam int YB = dstdr_pkg::Y_BITS;
    localparam int LB = dstdr_pkg::LEN_BITS;

    dstdr_pkg::state_t state_reg, state_next;
    dstdr_pkg::op_t    op_reg;
    logic [SB-1:0]     slot_reg;
    logic [dstdr_pkg::OWNER_BITS-1:0] owner_reg;
    logic [CB-1:0]     used_reg, used_next;
    logic [CB-1:0]     cursor_reg, cursor_next;
    logic [WB-1:0]     width_reg;
    logic [SB-1:0]     idx_reg, idx_next;
    logic [SB-1:0]     first_reg, first_next;
    logic              found_reg, found_next;
    dstdr_pkg::rsp_t   res_reg, res_next;

    logic              req_take;
    logic [WB-1:0]     weff;
    logic [WB-1:0]     sw;
    logic [3:0]        cap_shift;
    logic [CB-1:0]     geom;
    logic [CB-1:0]     cap;
    logic [CB-1:0]     last;
    logic [CB-1:0]     nxt;
    logic [RB-1:0]     smask;
    logic              boundary;
    logic              more;
    logic              fin;
    logic [SB-1:0]     fin_first;
    logic [CB-1:0]     fin_end;
    logic [CB-1:0]     run_slots;
    logic [SB+1:0]     tex;
    logic [XB-1:0]     xmask;

    assign req_take  = req_valid && !req_stall;
    assign req_stall = (state_reg != dstdr_pkg::S_IDLE);
    assign cfg_ready = (state_reg == dstdr_pkg::S_IDLE);
    assign res_valid = (state_reg == dstdr_pkg::S_RESULT);
    assign res       = res_reg;

    // Geometry from the width register, clamped to the legal range.
    always_comb
    begin
        weff = width_reg;
        if (width_reg < dstdr_pkg::WLOG_MIN)
        begin
            weff = dstdr_pkg::WLOG_MIN;
        end
        else if (width_reg > dstdr_pkg::WLOG_MAX)
        begin
            weff = dstdr_pkg::WLOG_MAX;
        end
    end

    assign sw        = weff - dstdr_pkg::WLOG_MIN;
    assign cap_shift = {sw, 1'b0} + 4'd2;
    assign geom      = CB'(1) << cap_shift;
    assign cap       = (geom < CB'(dstdr_pkg::CAPACITY)) ? geom : CB'(dstdr_pkg::CAPACITY);
    assign smask     = ~({RB{1'b1}} << sw);
    assign xmask     = ~({XB{1'b1}} << weff);
    assign last      = used_reg - CB'(1);
    assign nxt       = CB'(idx_reg) + CB'(1);
    // The next slot opens a new row when its in-row bits are all zero.
    assign boundary  = ((nxt[RB-1:0] & smask) == '0);
    assign more      = (nxt < used_reg);
    assign run_slots = fin_end - CB'(fin_first);
    assign tex       = {fin_first, 2'b00};

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        found_next  = found_reg;
        res_next    = res_reg;
        fin         = 1'b0;
        fin_first   = first_reg;
        fin_end     = CB'(idx_reg);

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = idx_reg;
        ram_req.wr_data = '0;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = idx_reg;

        case (state_reg)
            dstdr_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = dstdr_pkg::S_DECODE;
                end
            end

            dstdr_pkg::S_DECODE:
            begin
                res_next            = '0;
                res_next.used_count = used_reg;
                state_next          = dstdr_pkg::S_RESULT;
                case (op_reg)
                    dstdr_pkg::OP_ADD:
                    begin
                        if (used_reg >= cap)
                        begin
                            res_next.status = dstdr_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_req.wr_en         = 1'b1;
                            ram_req.wr_addr       = used_reg[SB-1:0];
                            ram_req.wr_data.dirty = 1'b1;
                            ram_req.wr_data.owner = owner_reg;
                            used_next             = used_reg + CB'(1);
                            res_next.slot_out     = used_reg[SB-1:0];
                            res_next.moved_owner  = owner_reg;
                            res_next.used_count   = used_reg + CB'(1);
                        end
                    end

                    dstdr_pkg::OP_REMOVE:
                    begin
                        if (CB'(slot_reg) >= used_reg)
                        begin
                            res_next.status = dstdr_pkg::ST_BAD_SLOT;
                        end
                        else if (CB'(slot_reg) == last)
                        begin
                            // Drop the mark; the vacated entry is rewritten before reuse.
                            ram_req.wr_en       = 1'b1;
                            ram_req.wr_addr     = slot_reg;
                            used_next           = last;
                            res_next.slot_out   = slot_reg;
                            res_next.used_count = last;
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = last[SB-1:0];
                            state_next      = dstdr_pkg::S_RM_MOVE;
                        end
                    end

                    dstdr_pkg::OP_NEXT_RUN:
                    begin
                        if (cursor_reg >= used_reg)
                        begin
                            res_next.status = dstdr_pkg::ST_NO_RUN;
                            cursor_next     = '0;
                        end
                        else
                        begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = cursor_reg[SB-1:0];
                            idx_next        = cursor_reg[SB-1:0];
                            found_next      = 1'b0;
                            state_next      = dstdr_pkg::S_SCAN;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            dstdr_pkg::S_RM_MOVE:
            begin
                // Last entry arrived from RAM: write it into the hole, dirty.
                ram_req.wr_en         = 1'b1;
                ram_req.wr_addr       = slot_reg;
                ram_req.wr_data.dirty = 1'b1;
                ram_req.wr_data.owner = ram_rd.owner;
                used_next             = last;
                res_next              = '0;
                res_next.slot_out     = slot_reg;
                res_next.moved        = 1'b1;
                res_next.moved_owner  = ram_rd.owner;
                res_next.copy_from    = last[SB-1:0];
                res_next.used_count   = last;
                state_next            = dstdr_pkg::S_RESULT;
            end

            dstdr_pkg::S_SCAN:
            begin
                // Data for idx_reg is on the RAM output; prefetch idx_reg + 1 when the scan goes on.
                if (ram_rd.dirty)
                begin
                    ram_req.wr_en         = 1'b1;
                    ram_req.wr_addr       = idx_reg;
                    ram_req.wr_data.dirty = 1'b0;
                    ram_req.wr_data.owner = ram_rd.owner;
                    if (!found_reg)
                    begin
                        first_next = idx_reg;
                        found_next = 1'b1;
                        fin_first  = idx_reg;
                    end
                    if (more && !boundary)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = nxt[SB-1:0];
                        idx_next        = nxt[SB-1:0];
                    end
                    else
                    begin
                        fin     = 1'b1;
                        fin_end = nxt;
                    end
                end
                else if (found_reg)
                begin
                    fin     = 1'b1;
                    fin_end = CB'(idx_reg);
                end
                else if (more)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = nxt[SB-1:0];
                    idx_next        = nxt[SB-1:0];
                end
                else
                begin
                    res_next            = '0;
                    res_next.status     = dstdr_pkg::ST_NO_RUN;
                    res_next.used_count = used_reg;
                    cursor_next         = '0;
                    state_next          = dstdr_pkg::S_RESULT;
                end

                if (fin)
                begin
                    res_next                = '0;
                    res_next.run_x          = XB'(tex) & xmask;
                    res_next.run_y          = YB'(fin_first >> sw);
                    res_next.run_len        = LB'(run_slots << dstdr_pkg::TEXEL_SHIFT);
                    res_next.run_first_slot = fin_first;
                    res_next.used_count     = used_reg;
                    cursor_next             = fin_end;
                    state_next              = dstdr_pkg::S_RESULT;
                end
            end

            dstdr_pkg::S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = dstdr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dstdr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dstdr_pkg::S_IDLE;
            used_reg   <= '0;
            cursor_reg <= '0;
            width_reg  <= dstdr_pkg::WLOG_RESET;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            cursor_reg <= cursor_next;
            found_reg  <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        if (req_take)
        begin
            op_reg    <= dstdr_pkg::op_t'(opcode);
            slot_reg  <= slot_in;
            owner_reg <= owner_in;
        end
    end

endmodule

@@ rtl/core/dstdr_rsp_buf.sv @@
// Output register for result transactions; frees the sequencer while a result
// waits downstream. Depends on dstdr_pkg.
module dstdr_rsp_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    output logic            res_ready,
    input  dstdr_pkg::rsp_t res,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dstdr_pkg::rsp_t rsp
);

    logic            valid_reg;
    dstdr_pkg::rsp_t data_reg;

    assign res_ready = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for dense_slot_table_dirty_runs_core: add, remove, dirty-run scans.
// Uses dstdr_pkg for port widths, opcodes and status codes. Needs only the RTL under rtl/core.
// A shadow slot table predicts every response; a scoreboard checks each field in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        dstdr_pkg::op_t                   op;
        logic [dstdr_pkg::SLOT_BITS-1:0]  slot;
        logic [dstdr_pkg::OWNER_BITS-1:0] owner;
    } table_cmd_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    logic [1:0]                       opcode = dstdr_pkg::OP_NOP;
    logic [dstdr_pkg::SLOT_BITS-1:0]  slot_in = '0;
    logic [dstdr_pkg::OWNER_BITS-1:0] owner_in = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    logic [1:0]                       status;
    logic [dstdr_pkg::SLOT_BITS-1:0]  slot_out;
    logic                             moved;
    logic [dstdr_pkg::OWNER_BITS-1:0] moved_owner;
    logic [dstdr_pkg::SLOT_BITS-1:0]  copy_from;
    logic [dstdr_pkg::X_BITS-1:0]     run_x;
    logic [dstdr_pkg::Y_BITS-1:0]     run_y;
    logic [dstdr_pkg::LEN_BITS-1:0]   run_len;
    logic [dstdr_pkg::SLOT_BITS-1:0]  run_first_slot;
    logic [dstdr_pkg::COUNT_BITS-1:0] used_count;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dstdr_pkg::WLOG_BITS-1:0]  cfg_data = '0;

    // shadow slot table
    logic [dstdr_pkg::WLOG_BITS-1:0]  tbl_width = dstdr_pkg::WLOG_RESET;
    int                               tbl_used = 0;
    int                               tbl_cursor = 0;
    bit                               dirty_mark [dstdr_pkg::CAPACITY];
    bit [dstdr_pkg::OWNER_BITS-1:0]   owner_at [dstdr_pkg::CAPACITY];

    table_cmd_t                       cmd_q [$];
    dstdr_pkg::rsp_t                  predicted_rsp_q [$];

    bit req_fire = 1'b0;
    bit steady = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int free_left = 0;
    int idle_cycles = 0;
    int gen_used = 0;
    int gen_cap = dstdr_pkg::CAPACITY;
    int gen_counted = 0;

    int n_err = 0, n_checked = 0, n_widths = 0, peak_used = 0;
    int n_add = 0, n_remove = 0, n_scan = 0, n_nop = 0;
    int n_full = 0, n_bad = 0, n_move = 0, n_run = 0, n_exhausted = 0;

    dense_slot_table_dirty_runs_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .opcode         (opcode),
        .slot_in        (slot_in),
        .owner_in       (owner_in),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .slot_out       (slot_out),
        .moved          (moved),
        .moved_owner    (moved_owner),
        .copy_from      (copy_from),
        .run_x          (run_x),
        .run_y          (run_y),
        .run_len        (run_len),
        .run_first_slot (run_first_slot),
        .used_count     (used_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_width(logic [dstdr_pkg::WLOG_BITS-1:0] value);
        int w;
        w = int'(value);
        if (w < int'(dstdr_pkg::WLOG_MIN))
            w = int'(dstdr_pkg::WLOG_MIN);
        if (w > int'(dstdr_pkg::WLOG_MAX))
            w = int'(dstdr_pkg::WLOG_MAX);
        return w;
    endfunction

    function automatic int slots_for_width(int w);
        int cap;
        cap = 1 << (2 * w - dstdr_pkg::TEXEL_SHIFT);
        return (cap > dstdr_pkg::CAPACITY) ? dstdr_pkg::CAPACITY : cap;
    endfunction

    // Apply one transaction to the shadow table and return the response it should give.
    function automatic dstdr_pkg::rsp_t table_predict(dstdr_pkg::op_t op,
                                                      logic [dstdr_pkg::SLOT_BITS-1:0] slot,
                                                      logic [dstdr_pkg::OWNER_BITS-1:0] owner);
        dstdr_pkg::rsp_t r;
        int              w, i, first, last, row, s;
        r = '0;
        w = clamp_width(tbl_width);
        s = int'(slot);
        case (op)
            dstdr_pkg::OP_ADD:
            begin
                if (tbl_used >= slots_for_width(w))
                    r.status = dstdr_pkg::ST_FULL;
                else
                begin
                    owner_at[tbl_used] = owner;
                    dirty_mark[tbl_used] = 1'b1;
                    r.slot_out = dstdr_pkg::SLOT_BITS'(tbl_used);
                    r.moved_owner = owner;
                    tbl_used++;
                end
            end
            dstdr_pkg::OP_REMOVE:
            begin
                if (s >= tbl_used)
                    r.status = dstdr_pkg::ST_BAD_SLOT;
                else
                begin
                    last = tbl_used - 1;
                    r.slot_out = slot;
                    if (s == last)
                        dirty_mark[s] = 1'b0;
                    else
                    begin
                        // fill the hole with the last entry
                        owner_at[s] = owner_at[last];
                        dirty_mark[s] = 1'b1;
                        dirty_mark[last] = 1'b0;
                        r.moved = 1'b1;
                        r.moved_owner = owner_at[s];
                        r.copy_from = dstdr_pkg::SLOT_BITS'(last);
                    end
                    tbl_used = last;
                end
            end
            dstdr_pkg::OP_NEXT_RUN:
            begin
                i = tbl_cursor;
                while (i < tbl_used && !dirty_mark[i])
                    i++;
                if (i >= tbl_used)
                begin
                    r.status = dstdr_pkg::ST_NO_RUN;
                    tbl_cursor = 0;
                end
                else
                begin
                    first = i;
                    row = (first << dstdr_pkg::TEXEL_SHIFT) >> w;
                    dirty_mark[i] = 1'b0;
                    i++;
                    // extend over dirty neighbors on the same texel row
                    while (i < tbl_used && dirty_mark[i]
                           && ((i << dstdr_pkg::TEXEL_SHIFT) >> w) == row)
                    begin
                        dirty_mark[i] = 1'b0;
                        i++;
                    end
                    tbl_cursor = i;
                    r.run_x = dstdr_pkg::X_BITS'((first << dstdr_pkg::TEXEL_SHIFT)
                                                 & ((1 << w) - 1));
                    r.run_y = dstdr_pkg::Y_BITS'(row);
                    r.run_len = dstdr_pkg::LEN_BITS'((i - first) << dstdr_pkg::TEXEL_SHIFT);
                    r.run_first_slot = dstdr_pkg::SLOT_BITS'(first);
                end
            end
            default:
            begin
            end
        endcase
        r.used_count = dstdr_pkg::COUNT_BITS'(tbl_used);
        return r;
    endfunction

    function automatic string rsp_str(dstdr_pkg::rsp_t r);
        return {$sformatf("st=%0d slot=%0d mv=%0b own=%h from=%0d ",
                          r.status, r.slot_out, r.moved, r.moved_owner, r.copy_from),
                $sformatf("x=%0d y=%0d len=%0d first=%0d used=%0d",
                          r.run_x, r.run_y, r.run_len, r.run_first_slot, r.used_count)};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int pick_owner();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return (1 << dstdr_pkg::OWNER_BITS) - 1;
        return $urandom_range((1 << dstdr_pkg::OWNER_BITS) - 1);
    endfunction

    // Request driver: present queued transactions, hold while stalled, insert random gaps unless steady.
    always @(negedge clk)
    begin : req_driver
        table_cmd_t cmd;
        if (rst_n)
        begin
            if (req_fire)
                gap_left = steady ? 0 : pick_gap();
            if (req_valid && !req_fire)
            begin
                // hold the stalled transaction
            end
            else if (gap_left > 0 || cmd_q.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                cmd = cmd_q.pop_front();
                opcode <= cmd.op;
                slot_in <= cmd.slot;
                owner_in <= cmd.owner;
                req_valid <= 1'b1;
            end
        end
    end

    // Response back-pressure: alternating free and stalled stretches of random length; none when steady.
    always @(negedge clk)
    begin : rsp_staller
        if (rst_n)
        begin
            if (steady)
            begin
                stall_left = 0;
                free_left = 0;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                rsp_stall <= 1'b0;
            end
            else
            begin
                free_left = $urandom_range(8);
                stall_left = pick_gap();
                rsp_stall <= 1'b0;
            end
        end
    end

    // Monitor and scoreboard: predict on request accept, check on response accept.
    always @(posedge clk)
    begin : monitor
        dstdr_pkg::rsp_t want;
        dstdr_pkg::rsp_t got;
        bit              progress;
        bit              bad;
        if (rst_n)
        begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                tbl_width = cfg_data;
                progress = 1'b1;
            end
            req_fire = req_valid && !req_stall;
            if (req_fire)
            begin
                progress = 1'b1;
                want = table_predict(dstdr_pkg::op_t'(opcode), slot_in, owner_in);
                predicted_rsp_q.push_back(want);
                case (dstdr_pkg::op_t'(opcode))
                    dstdr_pkg::OP_ADD:      n_add++;
                    dstdr_pkg::OP_REMOVE:   n_remove++;
                    dstdr_pkg::OP_NEXT_RUN: n_scan++;
                    default:                n_nop++;
                endcase
                if (want.status == dstdr_pkg::ST_FULL)
                    n_full++;
                if (want.status == dstdr_pkg::ST_BAD_SLOT)
                    n_bad++;
                if (want.status == dstdr_pkg::ST_NO_RUN)
                    n_exhausted++;
                if (want.moved)
                    n_move++;
                if (dstdr_pkg::op_t'(opcode) == dstdr_pkg::OP_NEXT_RUN
                    && want.status == dstdr_pkg::ST_OK)
                    n_run++;
                if (tbl_used > peak_used)
                    peak_used = tbl_used;
            end
            if (rsp_valid && !rsp_stall)
            begin
                progress = 1'b1;
                got.status = dstdr_pkg::status_t'(status);
                got.slot_out = slot_out;
                got.moved = moved;
                got.moved_owner = moved_owner;
                got.copy_from = copy_from;
                got.run_x = run_x;
                got.run_y = run_y;
                got.run_len = run_len;
                got.run_first_slot = run_first_slot;
                got.used_count = used_count;
                if (predicted_rsp_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: response with none pending: %s", $realtime, rsp_str(got));
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    n_checked++;
                    bad = (got.status !== want.status) || (got.slot_out !== want.slot_out)
                        || (got.moved !== want.moved) || (got.moved_owner !== want.moved_owner)
                        || (got.copy_from !== want.copy_from) || (got.run_x !== want.run_x)
                        || (got.run_y !== want.run_y) || (got.run_len !== want.run_len)
                        || (got.run_first_slot !== want.run_first_slot)
                        || (got.used_count !== want.used_count);
                    if (bad)
                    begin
                        n_err++;
                        if (n_err <= 10)
                        begin
                            $display("%0t: response %0d differs", $realtime, n_checked);
                            $display("  expected %s", rsp_str(want));
                            $display("  actual   %s", rsp_str(got));
                        end
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Queue one transaction and track the fill level it leaves behind.
    task automatic push_cmd(dstdr_pkg::op_t op, int slot, int owner);
        table_cmd_t c;
        c.op = op;
        c.slot = dstdr_pkg::SLOT_BITS'(slot);
        c.owner = dstdr_pkg::OWNER_BITS'(owner);
        cmd_q.push_back(c);
        if (op != dstdr_pkg::OP_NOP)
            gen_counted++;
        if (op == dstdr_pkg::OP_ADD && gen_used < gen_cap)
            gen_used++;
        else if (op == dstdr_pkg::OP_REMOVE && int'(c.slot) < gen_used)
            gen_used--;
    endtask

    task automatic push_random(int add_pct, int rm_pct);
        int r;
        int edge_slot;
        r = $urandom_range(99);
        edge_slot = (gen_used < dstdr_pkg::CAPACITY) ? gen_used : dstdr_pkg::CAPACITY - 1;
        if (r < 3)
            push_cmd(dstdr_pkg::OP_NOP, $urandom_range(dstdr_pkg::CAPACITY - 1), pick_owner());
        else if (r < 8)
            push_cmd(dstdr_pkg::OP_REMOVE,
                     $urandom_range(1) ? edge_slot : $urandom_range(dstdr_pkg::CAPACITY - 1),
                     pick_owner());
        else if (r < 8 + add_pct)
            push_cmd(dstdr_pkg::OP_ADD, $urandom_range(dstdr_pkg::CAPACITY - 1), pick_owner());
        else if (r < 8 + add_pct + rm_pct && gen_used > 0)
            push_cmd(dstdr_pkg::OP_REMOVE, ($urandom_range(3) == 0) ? gen_used - 1
                     : $urandom_range(gen_used - 1), pick_owner());
        else
            push_cmd(dstdr_pkg::OP_NEXT_RUN, $urandom_range(dstdr_pkg::CAPACITY - 1),
                     pick_owner());
    endtask

    task automatic wait_idle();
        while (cmd_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Change the texture width only with nothing in flight.
    task automatic write_width(logic [dstdr_pkg::WLOG_BITS-1:0] value);
        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_cap = slots_for_width(clamp_width(value));
        n_widths++;
    endtask

    task automatic run_phase(logic [dstdr_pkg::WLOG_BITS-1:0] width, int items, int add_pct,
                             int rm_pct, bit calm);
        int start;
        write_width(width);
        steady = calm;
        start = gen_counted;
        while (gen_counted - start < items)
            push_random(add_pct, rm_pct);
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, boundaries, removes with and without a move, run coalescing
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);
        push_cmd(dstdr_pkg::OP_REMOVE, dstdr_pkg::CAPACITY - 1, 16'hffff);
        push_cmd(dstdr_pkg::OP_NOP, dstdr_pkg::CAPACITY - 1, 16'hffff);
        push_cmd(dstdr_pkg::OP_ADD, 0, 0);
        push_cmd(dstdr_pkg::OP_ADD, dstdr_pkg::CAPACITY - 1, 16'hffff);
        push_cmd(dstdr_pkg::OP_ADD, 512, 16'h1234);
        push_cmd(dstdr_pkg::OP_ADD, 0, 16'h5a5a);
        push_cmd(dstdr_pkg::OP_REMOVE, 4, 0);
        push_cmd(dstdr_pkg::OP_REMOVE, 3, 0);
        push_cmd(dstdr_pkg::OP_REMOVE, 0, 0);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);

        // narrowest texture: one slot per row, four slots in all
        write_width(dstdr_pkg::WLOG_MIN);
        push_cmd(dstdr_pkg::OP_ADD, 0, 16'h0001);
        push_cmd(dstdr_pkg::OP_ADD, 0, 16'h8000);
        push_cmd(dstdr_pkg::OP_ADD, 0, 16'h7777);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);
        push_cmd(dstdr_pkg::OP_REMOVE, 1, 0);
        push_cmd(dstdr_pkg::OP_NEXT_RUN, 0, 0);

        run_phase(3'd0, 40, 45, 25, 1'b0);
        run_phase(3'd3, 70, 45, 25, 1'b1);
        run_phase(3'd1, 30, 35, 35, 1'b0);
        run_phase(3'd4, 70, 55, 20, 1'b0);
        run_phase(3'd5, 110, 70, 10, 1'b1);
        run_phase(dstdr_pkg::WLOG_MAX, 20, 86, 1, 1'b0);
        while (gen_used < gen_cap)
            push_random(86, 1);
        run_phase(3'd7, 30, 40, 30, 1'b1);
        // shrink under a full table: rows wrap past the row field width
        run_phase(3'd2, 40, 20, 40, 1'b0);

        wait_idle();
        repeat (20) @(posedge clk);
        n_err += predicted_rsp_q.size();

        $display("Covered %0d transactions: %0d add, %0d remove, %0d run request, %0d no-op.",
                  n_checked, n_add, n_remove, n_scan, n_nop);
        $display("Saw %0d widths, %0d full, %0d bad slot, %0d moves, %0d runs, %0d exhausted.",
                  n_widths, n_full, n_bad, n_move, n_run, n_exhausted);
        $display("Peak table fill %0d slots.", peak_used);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
